// File: src/wafbp_pkg.sv
// Shared types, codes and sizes of the wear-aware free block pool.
// No dependencies; the interfaces, the top level and the scan unit import this package.
package wafbp_pkg;

   localparam int NUM_BLOCKS  = 256;
   localparam int NUM_STREAMS = 16;
   localparam int BLK_W       = $clog2(NUM_BLOCKS);
   localparam int ADDR_W      = BLK_W + 1;
   localparam int CNT_W       = 9;
   localparam int EC_W        = 16;
   localparam int STAMP_W     = 32;
   localparam int STREAM_W    = 4;
   localparam int PAGE_W      = 21;
   localparam int PPB_W       = 13;
   localparam int PROD_W      = CNT_W + PPB_W;
   localparam int SLC_TOT_W   = 16;

   localparam logic [PAGE_W-1:0]    PAGE_MAX    = '1;
   localparam logic [SLC_TOT_W-1:0] SLC_TOT_MAX = '1;
   localparam logic [EC_W-1:0]      EC_MAX      = '1;
   localparam logic [PPB_W-1:0]     PPB_RESET   = PPB_W'(256);
   localparam logic [PAGE_W-1:0]    FREE_RESET  =
      (NUM_BLOCKS * 256 > 2097151) ? PAGE_W'(2097151) : PAGE_W'(NUM_BLOCKS * 256);

   typedef enum logic [2:0] {
      ACT_ADD_FREE     = 3'd0,
      ACT_ALLOCATE     = 3'd1,
      ACT_TO_SLC       = 3'd2,
      ACT_TO_TLC       = 3'd3,
      ACT_ERASE        = 3'd4,
      ACT_FIND_COLDEST = 3'd5,
      ACT_WEAR_SPREAD  = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      POOL_NONE   = 2'd0,
      POOL_NORMAL = 2'd1,
      POOL_SLC    = 2'd2
   } pool_type;

   typedef enum logic [1:0] {
      SCAN_HEAD   = 2'd0,
      SCAN_COLD   = 2'd1,
      SCAN_SPREAD = 2'd2
   } scan_mode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_MODIFY,
      ST_SCAN,
      ST_COMMIT,
      ST_MOVE,
      ST_PAGES,
      ST_PLANE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [EC_W-1:0]     wear_cnt;
      logic                slc;
      pool_type            pool;
      logic [EC_W-1:0]     key;
      logic [STAMP_W-1:0]  stamp;
      logic [STREAM_W-1:0] stream;
      logic                mapping;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic               start;
      logic               valid;
      scan_mode_type      mode;
      pool_type           pool;
      logic               want_slc;
      logic [STAMP_W-1:0] stamp_now;
   } scan_ctrl_type;

   typedef struct packed {
      logic             found;
      logic [BLK_W-1:0] best_idx;
      entry_type        best_entry;
      logic [EC_W-1:0]  min_ec;
      logic [EC_W-1:0]  max_ec;
   } scan_res_type;

endpackage

// File: src/wafbp_if.sv
// Channel interfaces of the wear-aware free block pool: request, response, register write.
// Depends on wafbp_pkg for the field widths.
interface wafbp_req_if import wafbp_pkg::*;;
   logic                valid;
   logic                ready;
   logic [2:0]          action;
   logic [BLK_W-1:0]    blk_index;
   logic [STREAM_W-1:0] strm_tag;
   logic                for_mapping;
   logic                for_slc;
   logic                use_wear;
   logic [CNT_W-1:0]    move_count;

   modport source (output valid, action, blk_index, strm_tag, for_mapping, for_slc,
                   use_wear, move_count, input ready);
   modport sink (input valid, action, blk_index, strm_tag, for_mapping, for_slc,
                 use_wear, move_count, output ready);
endinterface

interface wafbp_rsp_if import wafbp_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 status;
   logic [BLK_W-1:0]     result_block;
   logic [EC_W-1:0]      wear_spread;
   logic [CNT_W-1:0]     normal_free_count;
   logic [CNT_W-1:0]     slc_free_count;
   logic [SLC_TOT_W-1:0] slc_block_total;
   logic [PAGE_W-1:0]    free_pages;
   logic [PAGE_W-1:0]    invalid_pages;

   modport source (output valid, status, result_block, wear_spread, normal_free_count,
                   slc_free_count, slc_block_total, free_pages, invalid_pages,
                   input ready);
   modport sink (input valid, status, result_block, wear_spread, normal_free_count,
                 slc_free_count, slc_block_total, free_pages, invalid_pages,
                 output ready);
endinterface

interface wafbp_csr_if import wafbp_pkg::*;;
   logic             valid;
   logic             ready;
   logic [PPB_W-1:0] pages_per_block;

   modport source (output valid, pages_per_block, input ready);
   modport sink (input valid, pages_per_block, output ready);
endinterface

// File: src/wear_aware_free_block_pool.sv
// Top level of the wear-aware free block pool for one flash plane.
// Depends on wafbp_pkg, wafbp_if, wafbp_ram and wafbp_scan.

// The per-block bookkeeping (erase count, SLC mark, pool membership, pool key,
// insertion stamp, stream tag and mapping mark) lives in one 256-entry table
// memory with a single read port; requests are served by reading that table
// and, where they change it, writing entries back. After reset the block writes
// the reset contents into every table entry and takes no request meanwhile;
// register writes are taken at any time. Add and erase each work on one entry.
// Allocate, find-coldest and wear-spread stream the whole table through the
// read port once. A move of N blocks repeats the pool-head scan of allocate
// once per block, then updates the page counters on a move into SLC. One
// request is worked on at a time; a finished response sits in an output
// register, and the next request is taken while it waits for its transfer.
module wear_aware_free_block_pool import wafbp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   wafbp_req_if.sink   req_ch,
   wafbp_rsp_if.source rsp_ch,
   wafbp_csr_if.sink   csr_ch
);

   state_type state_ff, state_in;

   // Request fields held for the whole operation.
   action_type          action_ff, action_in;
   logic [BLK_W-1:0]    bid_ff, bid_in;
   logic [STREAM_W-1:0] sid_ff, sid_in;
   logic                map_ff, map_in;
   logic                slc_ff, slc_in;
   logic                wear_ff, wear_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic [CNT_W-1:0]     move_left_ff, move_left_in;
   logic [ADDR_W-1:0]    scan_addr_ff, scan_addr_in;
   logic                 pipe_vld_ff, pipe_vld_in;
   logic [BLK_W-1:0]     pipe_idx_ff, pipe_idx_in;
   logic [STAMP_W-1:0]   stamp_ff, stamp_in;
   logic [CNT_W-1:0]     norm_cnt_ff, norm_cnt_in;
   logic [CNT_W-1:0]     slc_cnt_ff, slc_cnt_in;
   logic [PAGE_W-1:0]    free_ff, free_in;
   logic [PAGE_W-1:0]    inv_ff, inv_in;
   logic [SLC_TOT_W-1:0] slc_tot_ff, slc_tot_in;
   logic [PPB_W-1:0]     ppb_ff, ppb_in;
   logic [PROD_W-1:0]    pages_ff, pages_in;

   logic             status_ff, status_in;
   logic [BLK_W-1:0] result_ff, result_in;
   logic [EC_W-1:0]  spread_ff, spread_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic [BLK_W-1:0]     rsp_result_ff, rsp_result_in;
   logic [EC_W-1:0]      rsp_spread_ff, rsp_spread_in;
   logic [CNT_W-1:0]     rsp_norm_ff, rsp_norm_in;
   logic [CNT_W-1:0]     rsp_slc_ff, rsp_slc_in;
   logic [SLC_TOT_W-1:0] rsp_slc_tot_ff, rsp_slc_tot_in;
   logic [PAGE_W-1:0]    rsp_free_ff, rsp_free_in;
   logic [PAGE_W-1:0]    rsp_inv_ff, rsp_inv_in;

   logic               ram_we;
   logic [BLK_W-1:0]   ram_waddr;
   entry_type          ram_wdata;
   logic [BLK_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type          rd_entry;

   scan_ctrl_type scan_ctrl;
   scan_res_type  scan_res;

   logic             req_fire;
   action_type       req_action;
   logic [CNT_W-1:0] req_src_cnt;
   logic             req_in_range;
   logic             scan_issue;
   logic             scan_done;
   pool_type         head_pool;
   pool_type         move_to;
   logic             rsp_free_slot;

   assign req_fire      = req_ch.valid && req_ch.ready;
   assign req_action    = action_type'(req_ch.action);
   assign req_src_cnt   = (req_action == ACT_TO_SLC) ? norm_cnt_ff : slc_cnt_ff;
   assign req_in_range  = (ADDR_W'(req_ch.blk_index) < ADDR_W'(NUM_BLOCKS));
   assign scan_issue    = (scan_addr_ff < ADDR_W'(NUM_BLOCKS));
   assign scan_done     = !scan_issue && !pipe_vld_ff;
   assign rsp_free_slot = !rsp_valid_ff || rsp_ch.ready;
   assign rd_entry      = entry_type'(ram_rdata);

   assign move_to   = (action_ff == ACT_TO_SLC) ? POOL_SLC : POOL_NORMAL;
   assign head_pool = (action_ff == ACT_ALLOCATE) ? (slc_ff ? POOL_SLC : POOL_NORMAL) :
                      ((action_ff == ACT_TO_SLC) ? POOL_NORMAL : POOL_SLC);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.status            = rsp_status_ff;
   assign rsp_ch.result_block      = rsp_result_ff;
   assign rsp_ch.wear_spread       = rsp_spread_ff;
   assign rsp_ch.normal_free_count = rsp_norm_ff;
   assign rsp_ch.slc_free_count    = rsp_slc_ff;
   assign rsp_ch.slc_block_total   = rsp_slc_tot_ff;
   assign rsp_ch.free_pages        = rsp_free_ff;
   assign rsp_ch.invalid_pages     = rsp_inv_ff;

   // Block table.
   wafbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // The scan unit sees one table entry per cycle, in the cycle after its read.
   always_comb begin
      scan_ctrl.start     = (state_in == ST_SCAN) && (state_ff != ST_SCAN);
      scan_ctrl.valid     = pipe_vld_ff;
      scan_ctrl.pool      = head_pool;
      scan_ctrl.want_slc  = slc_ff;
      scan_ctrl.stamp_now = stamp_ff;
      case (action_ff)
         ACT_FIND_COLDEST: scan_ctrl.mode = SCAN_COLD;
         ACT_WEAR_SPREAD:  scan_ctrl.mode = SCAN_SPREAD;
         default:          scan_ctrl.mode = SCAN_HEAD;
      endcase
   end

   wafbp_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctrl  (scan_ctrl),
      .entry (rd_entry),
      .idx   (pipe_idx_ff),
      .res   (scan_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (scan_addr_ff == ADDR_W'(NUM_BLOCKS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_action)
                  ACT_ADD_FREE, ACT_ERASE: begin
                     state_in = req_in_range ? ST_FETCH : ST_DONE;
                  end
                  ACT_ALLOCATE: begin
                     if (req_ch.for_slc) begin
                        state_in = (slc_cnt_ff == '0) ? ST_DONE : ST_SCAN;
                     end else begin
                        state_in = (norm_cnt_ff == '0) ? ST_DONE : ST_SCAN;
                     end
                  end
                  ACT_TO_SLC, ACT_TO_TLC: begin
                     state_in = (req_src_cnt < req_ch.move_count) ? ST_DONE : ST_MOVE;
                  end
                  ACT_FIND_COLDEST, ACT_WEAR_SPREAD: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_FETCH:  state_in = ST_MODIFY;
         ST_MODIFY: state_in = ST_DONE;
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (action_ff inside {ACT_TO_SLC, ACT_TO_TLC}) begin
               state_in = ST_MOVE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MOVE: begin
            if (move_left_ff != '0) begin
               state_in = ST_SCAN;
            end else if (action_ff == ACT_TO_SLC) begin
               state_in = ST_PAGES;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PAGES: state_in = ST_PLANE;
         ST_PLANE: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free_slot) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Datapath and table accesses for each state.
   always_comb begin
      entry_type        e;
      logic [CNT_W-1:0] left_next;
      logic [PAGE_W:0]  inv_sum;
      logic [SLC_TOT_W:0] slc_sum;

      action_in    = action_ff;
      bid_in       = bid_ff;
      sid_in       = sid_ff;
      map_in       = map_ff;
      slc_in       = slc_ff;
      wear_in      = wear_ff;
      cnt_in       = cnt_ff;
      move_left_in = move_left_ff;
      scan_addr_in = scan_addr_ff;
      pipe_vld_in  = 1'b0;
      pipe_idx_in  = pipe_idx_ff;
      stamp_in     = stamp_ff;
      norm_cnt_in  = norm_cnt_ff;
      slc_cnt_in   = slc_cnt_ff;
      free_in      = free_ff;
      inv_in       = inv_ff;
      slc_tot_in   = slc_tot_ff;
      pages_in     = pages_ff;
      status_in    = status_ff;
      result_in    = result_ff;
      spread_in    = spread_ff;
      ppb_in       = (csr_ch.valid && csr_ch.ready) ? csr_ch.pages_per_block : ppb_ff;

      rsp_valid_in   = (rsp_valid_ff && rsp_ch.ready) ? 1'b0 : rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_result_in  = rsp_result_ff;
      rsp_spread_in  = rsp_spread_ff;
      rsp_norm_in    = rsp_norm_ff;
      rsp_slc_in     = rsp_slc_ff;
      rsp_slc_tot_in = rsp_slc_tot_ff;
      rsp_free_in    = rsp_free_ff;
      rsp_inv_in     = rsp_inv_ff;

      ram_we    = 1'b0;
      ram_waddr = scan_addr_ff[BLK_W-1:0];
      ram_wdata = rd_entry;
      ram_raddr = scan_addr_ff[BLK_W-1:0];

      e         = scan_res.best_entry;
      left_next = move_left_ff - CNT_W'(1);
      inv_sum   = '0;
      slc_sum   = '0;

      if (state_in == ST_SCAN && state_ff != ST_SCAN) begin
         scan_addr_in = '0;
      end

      case (state_ff)
         ST_CLEAR: begin
            // Reset contents: normal pool, stamp equal to the block index.
            ram_we              = 1'b1;
            ram_wdata           = '0;
            ram_wdata.pool      = POOL_NORMAL;
            ram_wdata.stamp     = STAMP_W'(scan_addr_ff);
            scan_addr_in        = scan_addr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               action_in    = req_action;
               bid_in       = req_ch.blk_index;
               sid_in       = req_ch.strm_tag;
               map_in       = req_ch.for_mapping;
               slc_in       = req_ch.for_slc;
               wear_in      = req_ch.use_wear;
               cnt_in       = req_ch.move_count;
               move_left_in = req_ch.move_count;
               result_in    = '0;
               spread_in    = '0;
               status_in    = 1'b0;
               if (req_action == ACT_ALLOCATE) begin
                  if (req_ch.for_slc ? (slc_cnt_ff == '0) : (norm_cnt_ff == '0)) begin
                     status_in = 1'b1;
                  end
               end
               if ((req_action inside {ACT_TO_SLC, ACT_TO_TLC}) &&
                   (req_src_cnt < req_ch.move_count)) begin
                  status_in = 1'b1;
               end
               if (state_in == ST_SCAN) begin
                  scan_addr_in = '0;
               end
            end
         end
         ST_FETCH: begin
            ram_raddr = bid_ff;
         end
         ST_MODIFY: begin
            ram_waddr = bid_ff;
            ram_wdata = rd_entry;
            if (action_ff == ACT_ADD_FREE) begin
               if (rd_entry.pool == POOL_NONE) begin
                  ram_we          = 1'b1;
                  ram_wdata.pool  = POOL_NORMAL;
                  ram_wdata.key   = wear_ff ? rd_entry.wear_cnt : '0;
                  ram_wdata.stamp = stamp_ff;
                  stamp_in        = stamp_ff + STAMP_W'(1);
                  norm_cnt_in     = norm_cnt_ff + CNT_W'(1);
               end
            end else begin
               ram_we = 1'b1;
               if (rd_entry.wear_cnt != EC_MAX) begin
                  ram_wdata.wear_cnt = rd_entry.wear_cnt + EC_W'(1);
               end
               ram_wdata.slc     = 1'b0;
               ram_wdata.stream  = '0;
               ram_wdata.mapping = 1'b0;
            end
         end
         ST_SCAN: begin
            if (scan_issue) begin
               ram_raddr    = scan_addr_ff[BLK_W-1:0];
               pipe_vld_in  = 1'b1;
               pipe_idx_in  = scan_addr_ff[BLK_W-1:0];
               scan_addr_in = scan_addr_ff + ADDR_W'(1);
            end
         end
         ST_COMMIT: begin
            ram_waddr = scan_res.best_idx;
            case (action_ff)
               ACT_ALLOCATE: begin
                  ram_we            = 1'b1;
                  ram_wdata         = e;
                  ram_wdata.pool    = POOL_NONE;
                  ram_wdata.stream  = (int'(sid_ff) >= NUM_STREAMS) ?
                                      STREAM_W'(NUM_STREAMS - 1) : sid_ff;
                  ram_wdata.mapping = map_ff;
                  result_in         = scan_res.best_idx;
                  if (slc_ff) begin
                     slc_cnt_in = slc_cnt_ff - CNT_W'(1);
                  end else begin
                     norm_cnt_in = norm_cnt_ff - CNT_W'(1);
                  end
               end
               ACT_TO_SLC, ACT_TO_TLC: begin
                  ram_we          = 1'b1;
                  ram_wdata       = e;
                  ram_wdata.slc   = (move_to == POOL_SLC);
                  ram_wdata.pool  = move_to;
                  ram_wdata.key   = wear_ff ? e.wear_cnt : '0;
                  ram_wdata.stamp = stamp_ff;
                  stamp_in        = stamp_ff + STAMP_W'(1);
                  move_left_in    = left_next;
                  if (move_to == POOL_SLC) begin
                     norm_cnt_in = norm_cnt_ff - CNT_W'(1);
                     slc_cnt_in  = slc_cnt_ff + CNT_W'(1);
                  end else begin
                     slc_cnt_in  = slc_cnt_ff - CNT_W'(1);
                     norm_cnt_in = norm_cnt_ff + CNT_W'(1);
                  end
               end
               ACT_FIND_COLDEST: begin
                  if (scan_res.found) begin
                     result_in = scan_res.best_idx;
                  end else begin
                     status_in = 1'b1;
                  end
               end
               ACT_WEAR_SPREAD: begin
                  spread_in = scan_res.found ? (scan_res.max_ec - scan_res.min_ec) : '0;
               end
               default: begin
                  ram_we = 1'b0;
               end
            endcase
         end
         ST_PAGES: begin
            pages_in = PROD_W'(cnt_ff) * PROD_W'(ppb_ff);
         end
         ST_PLANE: begin
            // Free pages floor at zero; invalid pages and SLC total saturate.
            free_in = (PROD_W'(free_ff) <= pages_ff) ? '0 :
                      (free_ff - pages_ff[PAGE_W-1:0]);
            inv_sum = (PAGE_W+1)'(inv_ff) + (PAGE_W+1)'(pages_ff);
            inv_in  = (inv_sum > (PAGE_W+1)'(PAGE_MAX)) ? PAGE_MAX : inv_sum[PAGE_W-1:0];
            slc_sum = (SLC_TOT_W+1)'(slc_tot_ff) + (SLC_TOT_W+1)'(cnt_ff);
            slc_tot_in = (slc_sum > (SLC_TOT_W+1)'(SLC_TOT_MAX)) ? SLC_TOT_MAX :
                         slc_sum[SLC_TOT_W-1:0];
         end
         ST_DONE: begin
            if (rsp_free_slot) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_result_in  = result_ff;
               rsp_spread_in  = spread_ff;
               rsp_norm_in    = norm_cnt_ff;
               rsp_slc_in     = slc_cnt_ff;
               rsp_slc_tot_in = slc_tot_ff;
               rsp_free_in    = free_ff;
               rsp_inv_in     = inv_ff;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_addr_ff <= '0;
         pipe_vld_ff  <= 1'b0;
         move_left_ff <= '0;
         stamp_ff     <= STAMP_W'(NUM_BLOCKS);
         norm_cnt_ff  <= CNT_W'(NUM_BLOCKS);
         slc_cnt_ff   <= '0;
         free_ff      <= FREE_RESET;
         inv_ff       <= '0;
         slc_tot_ff   <= '0;
         ppb_ff       <= PPB_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_addr_ff <= scan_addr_in;
         pipe_vld_ff  <= pipe_vld_in;
         move_left_ff <= move_left_in;
         stamp_ff     <= stamp_in;
         norm_cnt_ff  <= norm_cnt_in;
         slc_cnt_ff   <= slc_cnt_in;
         free_ff      <= free_in;
         inv_ff       <= inv_in;
         slc_tot_ff   <= slc_tot_in;
         ppb_ff       <= ppb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      bid_ff         <= bid_in;
      sid_ff         <= sid_in;
      map_ff         <= map_in;
      slc_ff         <= slc_in;
      wear_ff        <= wear_in;
      cnt_ff         <= cnt_in;
      pipe_idx_ff    <= pipe_idx_in;
      pages_ff       <= pages_in;
      status_ff      <= status_in;
      result_ff      <= result_in;
      spread_ff      <= spread_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_result_ff  <= rsp_result_in;
      rsp_spread_ff  <= rsp_spread_in;
      rsp_norm_ff    <= rsp_norm_in;
      rsp_slc_ff     <= rsp_slc_in;
      rsp_slc_tot_ff <= rsp_slc_tot_in;
      rsp_free_ff    <= rsp_free_in;
      rsp_inv_ff     <= rsp_inv_in;
   end

   // Every block sits in at most one pool.
   a_pool_total: assert property (@(posedge clock) disable iff (reset)
      ((CNT_W+1)'(norm_cnt_ff) + (CNT_W+1)'(slc_cnt_ff)) <= (CNT_W+1)'(NUM_BLOCKS))
      else $error("pool counts exceed the number of blocks");

   // A pool-head scan is only started on a pool known to be non-empty.
   a_head_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT &&
       (action_ff == ACT_ALLOCATE || action_ff == ACT_TO_SLC || action_ff == ACT_TO_TLC))
      |-> scan_res.found)
      else $error("pool head scan found no member");

   // The remaining blocks of a move are always available in the source pool.
   a_move_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE) |->
      (move_left_ff <= ((action_ff == ACT_TO_SLC) ? norm_cnt_ff : slc_cnt_ff)))
      else $error("move outruns its source pool");

   // A response is only raised out of the completion state.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside completion");

endmodule

// File: src/wafbp_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module wafbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: src/wafbp_scan.sv
// Scan unit: watches the block table stream past and keeps the best candidate
// (pool head, coldest block) and the erase-count extremes. Depends on wafbp_pkg.
module wafbp_scan import wafbp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  scan_ctrl_type    ctrl,
   input  entry_type        entry,
   input  logic [BLK_W-1:0] idx,
   output scan_res_type     res
);

   logic               found_ff;
   logic [BLK_W-1:0]   idx_ff;
   entry_type          entry_ff;
   logic [STAMP_W-1:0] age_ff;
   logic [EC_W-1:0]    min_ff;
   logic [EC_W-1:0]    max_ff;
   logic [STAMP_W-1:0] age_cur;
   logic               qual;
   logic               better;

   always_comb begin
      age_cur = ctrl.stamp_now - entry.stamp;
      qual    = 1'b0;
      better  = 1'b0;
      case (ctrl.mode)
         SCAN_HEAD: begin
            qual   = (entry.pool == ctrl.pool);
            better = !found_ff || (entry.key < entry_ff.key) ||
                     ((entry.key == entry_ff.key) && (age_cur > age_ff));
         end
         SCAN_COLD: begin
            qual   = (entry.slc == ctrl.want_slc);
            better = !found_ff || (entry.wear_cnt < entry_ff.wear_cnt);
         end
         SCAN_SPREAD: begin
            qual   = !entry.slc;
            better = !found_ff;
         end
         default: begin
            qual   = 1'b0;
            better = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.start) begin
         found_ff <= 1'b0;
      end else if (ctrl.valid && qual) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!ctrl.start && ctrl.valid && qual) begin
         if (better) begin
            idx_ff   <= idx;
            entry_ff <= entry;
            age_ff   <= age_cur;
         end
         if (!found_ff || entry.wear_cnt < min_ff) begin
            min_ff <= entry.wear_cnt;
         end
         if (!found_ff || entry.wear_cnt > max_ff) begin
            max_ff <= entry.wear_cnt;
         end
      end
   end

   assign res.found      = found_ff;
   assign res.best_idx   = idx_ff;
   assign res.best_entry = entry_ff;
   assign res.min_ec     = min_ff;
   assign res.max_ec     = max_ff;

endmodule
